// ----- rtl/dhpt_pkg.sv -----
// Shared constants, codes and types for the double-hash probe table.
package dhpt_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_entry_t;

endpackage

// ----- rtl/dhpt_if.sv -----
// Request and result channel interfaces for the double-hash probe table.
interface dhpt_in_if;
  import dhpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  new_value;
  logic [SLOT_W-1:0] home_slot;
  logic [SLOT_W-1:0] probe_step;

  modport source (output valid, action, key, new_value, home_slot, probe_step,
                  input ready);
  modport sink (input valid, action, key, new_value, home_slot, probe_step,
                output ready);
endinterface

interface dhpt_out_if;
  import dhpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  found_value;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  occupancy;

  modport source (output valid, status, found_value, slot, occupancy,
                  input ready);
  modport sink (input valid, status, found_value, slot, occupancy,
                output ready);
endinterface

// ----- rtl/dhpt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dhpt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/double_hash_probe_table_top.sv -----
// Double-hash probe table: open-addressing key/value store, one slot probe per cycle.
//
// Requests arrive on in_ch (valid/ready): action, key, new_value, home_slot and
// probe_step, the last two computed by the host. Each accepted word yields one
// result word on out_ch: status, found_value, slot and occupancy.
// cfg_we/cfg_wdata set the bucket count (clamped to 2..1024); write it only
// while no request is in flight.
//
// The slot store is a single RAM with one read and one write port. Probing
// reads one slot per cycle with the compare in the cycle after the read; a
// request walks S_PROBE until a probe hits and then S_DONE loads the output
// register; a miss walks the full probe cycle (up to bucket count probes).
// Bad home/step and unknown actions skip S_PROBE and go straight to S_DONE.
// in_ch.ready rises together with out valid; requests are worked on one at a time.
//
// After reset the used marks are cleared by a pass over all 1024 slots, one slot
// a cycle, with in_ch.ready low. Results sit in an output register; a stalled
// receiver holds the word there, and the next request is still accepted and
// worked on, waiting only to hand over its result.
module double_hash_probe_table_top (
  input  logic                    clk,
  input  logic                    rst_n,
  dhpt_in_if.sink                 in_ch,
  dhpt_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [dhpt_pkg::CNT_W-1:0] cfg_wdata
);
  import dhpt_pkg::*;

  localparam int SUM_W = SLOT_W + 1;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]    eff_n_r;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic [ACT_W-1:0]    act_r, act_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [SLOT_W-1:0]   home_r, home_nxt;
  logic [SLOT_W-1:0]   step_r, step_nxt;

  logic [SLOT_W-1:0]   probe_idx_r, probe_idx_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic                chk_last_r, chk_last_nxt;

  status_t             res_status_r, res_status_nxt;
  logic [VAL_W-1:0]    res_found_r, res_found_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [VAL_W-1:0]    out_found_r, out_found_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]    out_occ_r, out_occ_nxt;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  slot_entry_t         ram_wdata;
  slot_entry_t         ram_rdata;

  logic [SUM_W-1:0]    step_sum;
  logic [SUM_W-1:0]    next_idx_w;
  logic [SLOT_W-1:0]   next_idx;
  logic                hit;
  logic                bad_req;
  logic [CNT_W-1:0]    cfg_clamped;

  dhpt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(slot_entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe_idx_r),
    .rdata (ram_rdata)
  );

  // probe unit: (idx + step) mod n, both operands below n
  assign step_sum   = {1'b0, probe_idx_r} + {1'b0, step_r};
  assign next_idx_w = (step_sum >= SUM_W'(eff_n_r)) ? step_sum - SUM_W'(eff_n_r) : step_sum;
  assign next_idx   = next_idx_w[SLOT_W-1:0];

  assign hit = (act_r == ACT_INSERT) ? !ram_rdata.used
                                     : (ram_rdata.used && (ram_rdata.key == key_r));

  assign bad_req = (CNT_W'(in_ch.home_slot) >= eff_n_r) || (in_ch.probe_step == '0) ||
                   (CNT_W'(in_ch.probe_step) >= eff_n_r);

  always_comb begin
    cfg_clamped = cfg_wdata;
    if (cfg_wdata < CNT_W'(2)) begin
      cfg_clamped = CNT_W'(2);
    end else if (cfg_wdata > CNT_W'(CAPACITY)) begin
      cfg_clamped = CNT_W'(CAPACITY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      eff_n_r      <= CNT_W'(CAPACITY);
      count_r      <= '0;
      chk_vld_r    <= 1'b0;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      count_r      <= count_nxt;
      chk_vld_r    <= chk_vld_nxt;
      issue_done_r <= issue_done_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        eff_n_r <= cfg_clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    home_r       <= home_nxt;
    step_r       <= step_nxt;
    probe_idx_r  <= probe_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    chk_last_r   <= chk_last_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    count_nxt      = count_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    home_nxt       = home_r;
    step_nxt       = step_r;
    probe_idx_nxt  = probe_idx_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    chk_last_nxt   = chk_last_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    out_occ_nxt    = out_occ_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_idx_r;
    ram_wdata      = '0;
    in_ch.ready    = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
        if (clr_cnt_r == SLOT_W'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          act_nxt        = in_ch.action;
          key_nxt        = in_ch.key;
          val_nxt        = in_ch.new_value;
          home_nxt       = in_ch.home_slot;
          step_nxt       = in_ch.probe_step;
          probe_idx_nxt  = in_ch.home_slot;
          issue_done_nxt = 1'b0;
          chk_vld_nxt    = 1'b0;
          res_found_nxt  = '0;
          res_slot_nxt   = '0;
          if (in_ch.action != ACT_INSERT && in_ch.action != ACT_SEARCH &&
              in_ch.action != ACT_REMOVE) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end else if (bad_req) begin
            res_status_nxt = ST_BAD;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        // issue side: read at probe_idx_r, advance until the walk returns home
        if (!issue_done_r) begin
          chk_vld_nxt    = 1'b1;
          chk_idx_nxt    = probe_idx_r;
          chk_last_nxt   = (next_idx == home_r);
          issue_done_nxt = (next_idx == home_r);
          probe_idx_nxt  = next_idx;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        // compare side: data for chk_idx_r is on ram_rdata
        if (chk_vld_r) begin
          if (hit) begin
            res_status_nxt = ST_OK;
            res_slot_nxt   = chk_idx_r;
            chk_vld_nxt    = 1'b0;
            state_nxt      = S_DONE;
            if (act_r == ACT_INSERT) begin
              ram_we          = 1'b1;
              ram_wdata.used  = 1'b1;
              ram_wdata.key   = key_r;
              ram_wdata.value = val_r;
              if (count_r < CNT_W'(CAPACITY)) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end else begin
              res_found_nxt = ram_rdata.value;
              if (act_r == ACT_REMOVE) begin
                ram_we          = 1'b1;
                ram_wdata       = ram_rdata;
                ram_wdata.used  = 1'b0;
                if (count_r != '0) begin
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
          end else if (chk_last_r) begin
            res_status_nxt = (act_r == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
            chk_vld_nxt    = 1'b0;
            state_nxt      = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_slot_nxt   = res_slot_r;
          out_occ_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_value = out_found_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.occupancy   = out_occ_r;

endmodule

// ----- rtl/dhpt_checker.sv -----
// Port-level checks for the double-hash probe table, bound to the top level.
module dhpt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dhpt_pkg::STAT_W-1:0] out_status,
  input logic [dhpt_pkg::VAL_W-1:0]  out_found_value,
  input logic [dhpt_pkg::SLOT_W-1:0] out_slot,
  input logic [dhpt_pkg::CNT_W-1:0]  out_occupancy
);
  import dhpt_pkg::*;

  // clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !in_ready)
    else $error("request port ready during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("stalled result word changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_slot == '0) && (out_found_value == '0))
    else $error("failed request reports slot or value");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

endmodule

bind double_hash_probe_table_top dhpt_checker u_dhpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_value (out_ch.found_value),
  .out_slot        (out_ch.slot),
  .out_occupancy   (out_ch.occupancy)
);
